>>> rtl/mld_pkg.sv
package mld_pkg;

  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned QUARTER_BITS = ANGLE_BITS - 2;
  localparam int unsigned FRAC_BITS    = 14;
  localparam int unsigned SINE_BITS    = FRAC_BITS + 2;
  localparam int unsigned DYAW_BITS    = ANGLE_BITS + 1;

  localparam int unsigned ORIGIN_BITS  = 13;
  localparam int unsigned PITCH_BITS   = 15;
  localparam int unsigned SENS_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DAT_BITS = 16;

  localparam int unsigned TURN_QUARTER = 1 << QUARTER_BITS;
  localparam int unsigned PITCH_MARGIN = 104;

  localparam int unsigned POLY_Q      = 30;
  localparam int unsigned POLY_A_BITS = 31;
  localparam int unsigned POLY_B_BITS = 30;
  localparam int unsigned POLY_C_BITS = 27;
  localparam logic [POLY_A_BITS-1:0] POLY_A = 31'd1686629713;
  localparam logic [POLY_B_BITS-1:0] POLY_B = 30'd688904866;
  localparam logic [POLY_C_BITS-1:0] POLY_C = 27'd76016977;

  localparam int unsigned SINE_STAGES = 6;
  typedef logic [SINE_STAGES-1:0] sine_en_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_YAW    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_PITCH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSITIVITY = 3'd4;

  localparam logic [SENS_BITS-1:0] SENS_RESET = 16'd5215;

endpackage

>>> rtl/mld_sine.sv
module mld_sine (
  input  logic                                  clk_i,
  input  mld_pkg::sine_en_t                     en_i,
  input  logic [mld_pkg::ANGLE_BITS-1:0]        angle_i,
  output logic signed [mld_pkg::SINE_BITS-1:0]  sine_o
);

  localparam int unsigned QW  = mld_pkg::QUARTER_BITS;
  localparam int unsigned Q   = mld_pkg::POLY_Q;
  localparam int unsigned XW  = Q + 1;
  localparam int unsigned AW  = mld_pkg::POLY_A_BITS;
  localparam int unsigned BW  = mld_pkg::POLY_B_BITS;
  localparam int unsigned CW  = mld_pkg::POLY_C_BITS;
  localparam int unsigned FB  = mld_pkg::FRAC_BITS;
  localparam int unsigned SW  = mld_pkg::SINE_BITS;
  localparam int unsigned M1W = XW + CW;
  localparam int unsigned M2W = XW + BW;
  localparam int unsigned M3W = XW + AW;
  localparam int unsigned YW  = M3W - Q;

  logic [QW:0]   u;
  logic [XW-1:0] x_d;
  logic [2*XW-1:0] sq;
  logic [M1W-1:0] m1_d;
  logic [BW-1:0]  t1;
  logic [M2W-1:0] m2_d;
  logic [AW-1:0]  t2;
  logic [M3W-1:0] m3_d;
  logic [YW-1:0]  y;
  logic [YW-1:0]  y_sum;
  logic [SW-1:0]  mag;
  logic signed [SW-1:0] sine_d;

  logic [XW-1:0]  x_a_q, x_b_q, x_c_q, x_d_q;
  logic [XW-1:0]  x2_b_q, x2_c_q;
  logic [M1W-1:0] m1_c_q;
  logic [M2W-1:0] m2_d_q;
  logic [M3W-1:0] m3_e_q;
  logic           neg_a_q, neg_b_q, neg_c_q, neg_d_q, neg_e_q;
  logic signed [SW-1:0] sine_q;

  // fold the angle into the first quadrant
  always_comb begin
    if (angle_i[QW]) begin
      u = (QW+1)'(1 << QW) - {1'b0, angle_i[QW-1:0]};
    end else begin
      u = {1'b0, angle_i[QW-1:0]};
    end
    x_d = XW'(u) << (Q - QW);
  end

  assign sq   = x_a_q * x_a_q;
  assign m1_d = x2_b_q * mld_pkg::POLY_C;
  assign t1   = mld_pkg::POLY_B - BW'(m1_c_q[M1W-1:Q]);
  assign m2_d = x2_c_q * t1;
  assign t2   = mld_pkg::POLY_A - AW'(m2_d_q[M2W-1:Q]);
  assign m3_d = x_d_q * t2;

  // clamp to one, round to the output grid, apply the half-turn sign
  always_comb begin
    y = m3_e_q[M3W-1:Q];
    if (y > YW'(1 << Q)) begin
      y = YW'(1 << Q);
    end
    y_sum  = y + YW'(1 << (Q - 1 - FB));
    mag    = SW'(y_sum >> (Q - FB));
    sine_d = neg_e_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_a_q   <= x_d;
      neg_a_q <= angle_i[mld_pkg::ANGLE_BITS-1];
    end
    if (en_i[1]) begin
      x_b_q   <= x_a_q;
      x2_b_q  <= sq[Q +: XW];
      neg_b_q <= neg_a_q;
    end
    if (en_i[2]) begin
      x_c_q   <= x_b_q;
      x2_c_q  <= x2_b_q;
      m1_c_q  <= m1_d;
      neg_c_q <= neg_b_q;
    end
    if (en_i[3]) begin
      x_d_q   <= x_c_q;
      m2_d_q  <= m2_d;
      neg_d_q <= neg_c_q;
    end
    if (en_i[4]) begin
      m3_e_q  <= m3_d;
      neg_e_q <= neg_d_q;
    end
    if (en_i[5]) begin
      sine_q  <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

>>> rtl/mouse_look_direction_core.sv
// Pointer-driven look direction.
//
// Input channel (in_valid_i / in_ready_o) carries one pointer sample per
// request. Output channel (out_valid_o / out_ready_i) returns one result per
// sample: the Q1.14 unit look direction and the wrapped yaw and limited pitch
// deltas against the base angles. Results leave in request order.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes origin, base
// angles and sensitivity by index; always ready, it drops indexes past the
// list. The user must write it while no request is in flight (unenforced).
//
// An accepted request passes eleven pipeline stages to out_valid_o:
// offset, scale, wrap/limit, six stages of the quarter-wave sine
// polynomial, direction multiply and rounding.
// Throughput is one request per cycle while out_ready_i is high.
// When the receiver stalls, full stages hold and empty stages keep filling;
// in_ready_o drops only once every stage holds a request.
// Reset empties the pipeline and loads the register defaults.
module mouse_look_direction_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [COORD_BITS-1:0]                  pointer_x_i,
  input  logic [COORD_BITS-1:0]                  pointer_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [mld_pkg::SINE_BITS-1:0]   dir_x_o,
  output logic signed [mld_pkg::SINE_BITS-1:0]   dir_y_o,
  output logic signed [mld_pkg::SINE_BITS-1:0]   dir_z_o,
  output logic signed [mld_pkg::DYAW_BITS-1:0]   delta_yaw_o,
  output logic signed [mld_pkg::ANGLE_BITS-1:0]  delta_pitch_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mld_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [mld_pkg::CFG_DAT_BITS-1:0]       cfg_data_i
);

  localparam int unsigned OW      = mld_pkg::ORIGIN_BITS;
  localparam int unsigned PBW     = mld_pkg::PITCH_BITS;
  localparam int unsigned SNW     = mld_pkg::SENS_BITS;
  localparam int unsigned AW      = mld_pkg::ANGLE_BITS;
  localparam int unsigned SW      = mld_pkg::SINE_BITS;
  localparam int unsigned FB      = mld_pkg::FRAC_BITS;
  localparam int unsigned DYW     = mld_pkg::DYAW_BITS;
  localparam int unsigned DW      = ((COORD_BITS > OW) ? COORD_BITS : OW) + 2;
  localparam int unsigned PW      = DW + SNW + 1;
  localparam int unsigned STAGES  = 11;
  localparam int unsigned ANG_ST  = 2;
  localparam int unsigned SIN_ST  = 3;
  localparam int unsigned PROD_ST = SIN_ST + mld_pkg::SINE_STAGES;
  localparam int unsigned OUT_ST  = PROD_ST + 1;
  localparam logic signed [PW:0] P_HI = (PW+1)'(mld_pkg::TURN_QUARTER);
  localparam logic signed [PW:0] P_LO = -P_HI;
  localparam logic [AW-1:0] PITCH_TOP =
    AW'(mld_pkg::TURN_QUARTER - mld_pkg::PITCH_MARGIN);

  function automatic logic signed [SW-1:0] round_q(input logic signed [2*SW-1:0] p);
    logic [2*SW-1:0] mag;
    logic [2*SW-1:0] sum;
    logic signed [SW-1:0] r;
    mag = p[2*SW-1] ? (2*SW)'(-p) : (2*SW)'(p);
    sum = mag + (2*SW)'(1 << (FB - 1));
    r   = $signed(sum[FB +: SW]);
    return p[2*SW-1] ? -r : r;
  endfunction

  logic signed [OW-1:0]  origin_x_q, origin_y_q;
  logic signed [AW-1:0]  base_yaw_q;
  logic signed [PBW-1:0] base_pitch_q;
  logic [SNW-1:0]        sens_q;

  logic [STAGES:0]   en;
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_in;

  logic signed [DW-1:0] diff_x_d, diff_y_d, diff_x_q, diff_y_q;
  logic signed [PW-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [PW-1:0] ysum;
  logic signed [PW:0]   psum;
  logic [AW-1:0]        yaw_d, pitch_d, yaw_q, pitch_q;
  logic [DYW-1:0]       dyaw_d;
  logic [AW-1:0]        dpitch_d;
  logic [DYW-1:0]       dyaw_q   [ANG_ST:OUT_ST];
  logic [AW-1:0]        dpitch_q [ANG_ST:OUT_ST];

  mld_pkg::sine_en_t    sine_en;
  logic signed [SW-1:0] sy, cy, sp, cp;
  logic signed [2*SW-1:0] px_q, pz_q;
  logic signed [SW-1:0] ny_q;
  logic signed [SW-1:0] dir_x_q, dir_y_q, dir_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '1;
      origin_y_q   <= '1;
      base_yaw_q   <= '0;
      base_pitch_q <= '0;
      sens_q       <= mld_pkg::SENS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mld_pkg::REG_ORIGIN_X:    origin_x_q   <= cfg_data_i[OW-1:0];
        mld_pkg::REG_ORIGIN_Y:    origin_y_q   <= cfg_data_i[OW-1:0];
        mld_pkg::REG_BASE_YAW:    base_yaw_q   <= cfg_data_i[AW-1:0];
        mld_pkg::REG_BASE_PITCH:  base_pitch_q <= cfg_data_i[PBW-1:0];
        mld_pkg::REG_SENSITIVITY: sens_q       <= cfg_data_i[SNW-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its content moves on
  always_comb begin
    en[STAGES] = out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in     = {vld_q[STAGES-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign diff_x_d = $signed({{(DW-COORD_BITS){1'b0}}, pointer_x_i})
                  - {{(DW-OW){origin_x_q[OW-1]}}, origin_x_q};
  assign diff_y_d = $signed({{(DW-COORD_BITS){1'b0}}, pointer_y_i})
                  - {{(DW-OW){origin_y_q[OW-1]}}, origin_y_q};
  assign prod_x_d = diff_x_q * $signed({1'b0, sens_q});
  assign prod_y_d = diff_y_q * $signed({1'b0, sens_q});

  // wrap yaw, limit pitch
  always_comb begin
    ysum  = prod_x_q + {{(PW-AW){base_yaw_q[AW-1]}}, base_yaw_q};
    yaw_d = ysum[AW-1:0];
    psum  = {prod_y_q[PW-1], prod_y_q} + {{(PW+1-PBW){base_pitch_q[PBW-1]}}, base_pitch_q};
    if (psum > P_HI) begin
      pitch_d = PITCH_TOP;
    end else if (psum < P_LO) begin
      pitch_d = -PITCH_TOP;
    end else begin
      pitch_d = psum[AW-1:0];
    end
    dyaw_d   = {yaw_d[AW-1], yaw_d} - {base_yaw_q[AW-1], base_yaw_q};
    dpitch_d = pitch_d - {{(AW-PBW){base_pitch_q[PBW-1]}}, base_pitch_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      diff_x_q <= diff_x_d;
      diff_y_q <= diff_y_d;
    end
    if (en[1]) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (en[ANG_ST]) begin
      yaw_q            <= yaw_d;
      pitch_q          <= pitch_d;
      dyaw_q[ANG_ST]   <= dyaw_d;
      dpitch_q[ANG_ST] <= dpitch_d;
    end
    for (int k = ANG_ST + 1; k <= OUT_ST; k++) begin
      if (en[k]) begin
        dyaw_q[k]   <= dyaw_q[k-1];
        dpitch_q[k] <= dpitch_q[k-1];
      end
    end
    if (en[PROD_ST]) begin
      px_q <= sy * cp;
      pz_q <= cy * cp;
      ny_q <= -sp;
    end
    if (en[OUT_ST]) begin
      dir_x_q <= round_q(px_q);
      dir_y_q <= ny_q;
      dir_z_q <= -round_q(pz_q);
    end
  end

  assign sine_en = en[PROD_ST-1:SIN_ST];

  mld_sine u_sin_yaw (
    .clk_i   (clk_i),
    .en_i    (sine_en),
    .angle_i (yaw_q),
    .sine_o  (sy)
  );

  mld_sine u_cos_yaw (
    .clk_i   (clk_i),
    .en_i    (sine_en),
    .angle_i (yaw_q + AW'(mld_pkg::TURN_QUARTER)),
    .sine_o  (cy)
  );

  mld_sine u_sin_pitch (
    .clk_i   (clk_i),
    .en_i    (sine_en),
    .angle_i (pitch_q),
    .sine_o  (sp)
  );

  mld_sine u_cos_pitch (
    .clk_i   (clk_i),
    .en_i    (sine_en),
    .angle_i (pitch_q + AW'(mld_pkg::TURN_QUARTER)),
    .sine_o  (cp)
  );

  assign out_valid_o   = vld_q[OUT_ST];
  assign dir_x_o       = dir_x_q;
  assign dir_y_o       = dir_y_q;
  assign dir_z_o       = dir_z_q;
  assign delta_yaw_o   = $signed(dyaw_q[OUT_ST]);
  assign delta_pitch_o = $signed(dpitch_q[OUT_ST]);

endmodule

>>> rtl/mld_checker.sv
module mld_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [mld_pkg::SINE_BITS-1:0]   dir_x_o,
  input logic signed [mld_pkg::SINE_BITS-1:0]   dir_y_o,
  input logic signed [mld_pkg::SINE_BITS-1:0]   dir_z_o,
  input logic signed [mld_pkg::DYAW_BITS-1:0]   delta_yaw_o,
  input logic signed [mld_pkg::ANGLE_BITS-1:0]  delta_pitch_o
);

  localparam logic signed [mld_pkg::SINE_BITS-1:0] ONE =
    mld_pkg::SINE_BITS'(1 << mld_pkg::FRAC_BITS);

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dir_x_o) && $stable(dir_y_o)
      && $stable(dir_z_o) && $stable(delta_yaw_o) && $stable(delta_pitch_o))
    else $error("stalled result changed");

  a_dir_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dir_x_o <= ONE && dir_x_o >= -ONE && dir_y_o <= ONE
      && dir_y_o >= -ONE && dir_z_o <= ONE && dir_z_o >= -ONE)
    else $error("direction component out of range");

endmodule

bind mouse_look_direction_core mld_checker u_mld_checker (.*);
